// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/sgc_pkg.sv =====
// types, constants and microcode rom of the stereo gain and crossfeed block
package sgc_pkg;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int COUNT_W     = 48;
   localparam int GAIN1_W     = 32;
   localparam int GPROD_W     = 48;
   localparam int GAIN_W      = 28;
   localparam int GAIN_SHIFT  = 20;
   localparam int SAMPLE_SHIFT = 22;
   localparam int Q16_SHIFT   = 16;
   localparam int DELAY_W     = 7;
   localparam int STEP_W      = 4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PLAYING     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_PERFECT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_GAIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SW_VOLUME   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_REPLAY_GAIN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_XFEED_EN    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA       = 3'd7;

   localparam logic [15:0] UNITY_Q14 = 16'd16384;
   localparam logic [15:0] BLEED_Q16 = 16'd29491;
   localparam logic [15:0] ATTEN_Q16 = 16'd45875;
   localparam logic [15:0] RST_ALPHA = 16'd8173;
   localparam logic [DELAY_W-1:0] RST_DELAY = 7'd17;

   // multiply operations
   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_GAIN1   = 3'd1;
   localparam logic [2:0] OP_GAIN2   = 3'd2;
   localparam logic [2:0] OP_SAMPLE  = 3'd3;
   localparam logic [2:0] OP_LOWPASS = 3'd4;
   localparam logic [2:0] OP_BLEED   = 3'd5;
   localparam logic [2:0] OP_ATTEN   = 3'd6;

   // product writebacks
   localparam logic [2:0] WB_NONE    = 3'd0;
   localparam logic [2:0] WB_GAIN1   = 3'd1;
   localparam logic [2:0] WB_GAIN2   = 3'd2;
   localparam logic [2:0] WB_SAMPLE  = 3'd3;
   localparam logic [2:0] WB_LOWPASS = 3'd4;
   localparam logic [2:0] WB_BLEED   = 3'd5;
   localparam logic [2:0] WB_ATTEN   = 3'd6;

   // jump conditions
   localparam logic [1:0] JC_NONE = 2'd0;
   localparam logic [1:0] JC_MUTE = 2'd1;
   localparam logic [1:0] JC_DRY  = 2'd2;

   // finishing kinds
   localparam logic [1:0] FIN_NONE   = 2'd0;
   localparam logic [1:0] FIN_SAMPLE = 2'd1;
   localparam logic [1:0] FIN_MUTE   = 2'd2;

   localparam logic [STEP_W-1:0] STEP_DRY_END  = 4'd12;
   localparam logic [STEP_W-1:0] STEP_MUTE_END = 4'd13;

   typedef struct packed {
      logic               playing;
      logic               bit_perfect;
      logic [15:0]        output_gain;
      logic [15:0]        software_volume;
      logic [15:0]        replay_gain;
      logic               crossfeed_enable;
      logic [DELAY_W-1:0] delay_frames;
      logic [15:0]        lowpass_alpha;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      playing: 1'b0, bit_perfect: 1'b0,
      output_gain: UNITY_Q14, software_volume: UNITY_Q14, replay_gain: UNITY_Q14,
      crossfeed_enable: 1'b0, delay_frames: RST_DELAY, lowpass_alpha: RST_ALPHA};

   typedef struct packed {
      logic [2:0]        op;
      logic [2:0]        wb;
      logic              mem_rd;
      logic              mem_wr;
      logic [1:0]        jc;
      logic [STEP_W-1:0] target;
      logic [1:0]        fin;
   } ucode_type;

   localparam ucode_type UCODE_NOP = '{
      op: OP_NONE, wb: WB_NONE, mem_rd: 1'b0, mem_wr: 1'b0,
      jc: JC_NONE, target: 4'd0, fin: FIN_NONE};

   typedef struct packed {
      logic busy;
      logic finish;
   } seq_status_type;

   // one control word per step; a product lands in the step after its multiply
   function automatic ucode_type ucode_word(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = UCODE_NOP;
      case (step)
         4'd0: begin
            w.op = OP_GAIN1;
            w.mem_rd = 1'b1;
            w.jc = JC_MUTE;
            w.target = STEP_MUTE_END;
         end
         4'd1: w.wb = WB_GAIN1;
         4'd2: w.op = OP_GAIN2;
         4'd3: w.wb = WB_GAIN2;
         4'd4: w.op = OP_SAMPLE;
         4'd5: begin
            w.wb = WB_SAMPLE;
            w.jc = JC_DRY;
            w.target = STEP_DRY_END;
         end
         4'd6: begin
            w.op = OP_LOWPASS;
            w.mem_wr = 1'b1;
         end
         4'd7: w.wb = WB_LOWPASS;
         4'd8: w.op = OP_BLEED;
         4'd9: w.wb = WB_BLEED;
         4'd10: w.op = OP_ATTEN;
         4'd11: w.wb = WB_ATTEN;
         4'd12: w.fin = FIN_SAMPLE;
         4'd13: w.fin = FIN_MUTE;
         default: w = UCODE_NOP;
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/sgc_req_if.sv =====
// input channel: one stereo frame per transaction
interface sgc_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;
   logic                          frame_present;

   modport source (output valid, left_in, right_in, frame_present, input ready);
   modport sink (input valid, left_in, right_in, frame_present, output ready);
endinterface

// ===== hdl/sgc_rsp_if.sv =====
// result channel: one processed stereo frame per transaction
interface sgc_rsp_if import sgc_pkg::*; #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic [COUNT_W-1:0]            frames_played;

   modport source (output valid, left_out, right_out, frames_played, input ready);
   modport sink (input valid, left_out, right_out, frames_played, output ready);
endinterface

// ===== hdl/sgc_seq.sv =====
// microcode sequencer: step counter, rom lookup and conditional jumps
module sgc_seq import sgc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           out_free,
   input  cfg_type        cfg,
   output ucode_type      ctrl,
   output seq_status_type status
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              jump;
   logic              at_end;

   always_comb begin
      ctrl = busy_ff ? ucode_word(step_ff) : UCODE_NOP;
      case (ctrl.jc)
         JC_MUTE: jump = !cfg.playing;
         JC_DRY:  jump = !cfg.crossfeed_enable;
         default: jump = 1'b0;
      endcase
      at_end = (ctrl.fin != FIN_NONE);
      status.busy = busy_ff;
      status.finish = busy_ff && at_end && out_free;
   end

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (at_end) begin
            // hold on the last step until the result register is free
            if (out_free) busy_in = 1'b0;
         end else begin
            step_in = jump ? ctrl.target : step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// ===== hdl/sgc_dp.sv =====
// datapath: two multiplier lanes, sample registers, lowpass state and delay memory
module sgc_dp import sgc_pkg::*; #(
   parameter int DELAY_DEPTH = 128,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ucode_type                     ctrl,
   input  cfg_type                       cfg,
   input  logic                          load,
   input  logic signed [SAMPLE_BITS-1:0] left_in,
   input  logic signed [SAMPLE_BITS-1:0] right_in,
   output logic signed [SAMPLE_BITS-1:0] left_out,
   output logic signed [SAMPLE_BITS-1:0] right_out
);

   localparam int PTR_W = $clog2(DELAY_DEPTH);
   localparam int EW    = SAMPLE_BITS + 1;
   localparam int AW    = (EW > GAIN1_W + 1) ? EW : GAIN1_W + 1;
   localparam int BW    = GAIN_W + 1;
   localparam int PW    = AW + BW;
   localparam int DW    = ((PTR_W > DELAY_W) ? PTR_W : DELAY_W) + 1;
   localparam int SB    = SAMPLE_BITS;

   localparam logic signed [PW-1:0] HALF_SAMPLE = PW'(2**(SAMPLE_SHIFT-1));
   localparam logic signed [PW-1:0] HALF_Q16    = PW'(2**(Q16_SHIFT-1));
   localparam logic signed [PW-1:0] SMAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [PW-1:0] SMIN = ~SMAX;

   function automatic logic signed [SB-1:0] sat(input logic signed [PW-1:0] v);
      logic signed [SB-1:0] s;
      if (v > SMAX) s = SMAX[SB-1:0];
      else if (v < SMIN) s = SMIN[SB-1:0];
      else s = v[SB-1:0];
      return s;
   endfunction

   logic signed [SB-1:0] xl_ff, xl_in, xr_ff, xr_in;
   logic [GAIN1_W-1:0]   g1_ff, g1_in;
   logic [GAIN_W-1:0]    gain_ff, gain_in;
   logic signed [SB-1:0] l_ff, l_in, r_ff, r_in;
   logic signed [SB-1:0] sl_ff, sl_in, sr_ff, sr_in;
   logic signed [EW-1:0] nl_ff, nl_in, nr_ff, nr_in;
   logic signed [EW-1:0] diffl_ff, diffl_in, diffr_ff, diffr_in;
   logic signed [PW-1:0] prodl_ff, prodl_in, prodr_ff, prodr_in;
   logic [PTR_W-1:0]     ws_ff, ws_in;
   logic                 wrapped_ff, wrapped_in;
   logic [2*SB-1:0]      rdata_ff;
   logic                 rvalid_ff;
   logic [2*SB-1:0]      delay_mem_ff [DELAY_DEPTH];

   logic signed [AW-1:0] al, ar;
   logic signed [BW-1:0] bl, br;
   logic [15:0]          vol_eff;
   logic signed [PW-1:0] rl22, rr22, rl16, rr16;
   logic [GPROD_W-1:0]   gsum;
   logic [DW-1:0]        d_ext, d_clamp;
   logic [PTR_W:0]       ws_ext, d_wide, rsum;
   logic [PTR_W-1:0]     raddr;
   logic                 rd_hit;
   logic signed [SB-1:0] dl, dr;

   // operand selection for both lanes
   always_comb begin
      vol_eff = cfg.bit_perfect ? UNITY_Q14 : cfg.software_volume;
      al = '0;
      bl = '0;
      ar = '0;
      br = '0;
      case (ctrl.op)
         OP_GAIN1: begin
            al = AW'(cfg.output_gain);
            bl = BW'(vol_eff);
         end
         OP_GAIN2: begin
            al = AW'(g1_ff);
            bl = BW'(cfg.replay_gain);
         end
         OP_SAMPLE: begin
            al = AW'(xl_ff);
            bl = BW'(gain_ff);
            ar = AW'(xr_ff);
            br = BW'(gain_ff);
         end
         OP_LOWPASS: begin
            al = AW'(diffl_ff);
            bl = BW'(cfg.lowpass_alpha);
            ar = AW'(diffr_ff);
            br = BW'(cfg.lowpass_alpha);
         end
         OP_BLEED: begin
            // each side bleeds the opposite channel's smoothed signal
            al = AW'(sr_ff);
            bl = BW'(BLEED_Q16);
            ar = AW'(sl_ff);
            br = BW'(BLEED_Q16);
         end
         OP_ATTEN: begin
            al = AW'(nl_ff);
            bl = BW'(ATTEN_Q16);
            ar = AW'(nr_ff);
            br = BW'(ATTEN_Q16);
         end
         default: begin
            al = '0;
            bl = '0;
         end
      endcase
      prodl_in = al * bl;
      prodr_in = ar * br;
   end

   // round half up on the registered products
   always_comb begin
      rl22 = (prodl_ff + HALF_SAMPLE) >>> SAMPLE_SHIFT;
      rr22 = (prodr_ff + HALF_SAMPLE) >>> SAMPLE_SHIFT;
      rl16 = (prodl_ff + HALF_Q16) >>> Q16_SHIFT;
      rr16 = (prodr_ff + HALF_Q16) >>> Q16_SHIFT;
      gsum = prodl_ff[GPROD_W-1:0] + GPROD_W'(2**(GAIN_SHIFT-1));
   end

   always_comb begin
      xl_in = xl_ff;
      xr_in = xr_ff;
      g1_in = g1_ff;
      gain_in = gain_ff;
      l_in = l_ff;
      r_in = r_ff;
      sl_in = sl_ff;
      sr_in = sr_ff;
      nl_in = nl_ff;
      nr_in = nr_ff;
      if (load) begin
         xl_in = left_in;
         xr_in = right_in;
      end
      case (ctrl.wb)
         WB_GAIN1: g1_in = prodl_ff[GAIN1_W-1:0];
         WB_GAIN2: gain_in = gsum[GPROD_W-1:GAIN_SHIFT];
         WB_SAMPLE: begin
            l_in = sat(rl22);
            r_in = sat(rr22);
         end
         WB_LOWPASS: begin
            // the smoothed value stays between old state and input, no overflow
            sl_in = sl_ff + rl16[SB-1:0];
            sr_in = sr_ff + rr16[SB-1:0];
         end
         WB_BLEED: begin
            nl_in = EW'(l_ff) + rl16[EW-1:0];
            nr_in = EW'(r_ff) + rr16[EW-1:0];
         end
         WB_ATTEN: begin
            l_in = sat(rl16);
            r_in = sat(rr16);
         end
         default: begin
            g1_in = g1_ff;
         end
      endcase
   end

   // delay read address, delay clamped to 1 .. depth-1
   always_comb begin
      d_ext = DW'(cfg.delay_frames);
      d_clamp = d_ext;
      if (d_ext == '0) d_clamp = DW'(1);
      else if (d_ext > DW'(DELAY_DEPTH - 1)) d_clamp = DW'(DELAY_DEPTH - 1);
      ws_ext = (PTR_W+1)'(ws_ff);
      d_wide = d_clamp[PTR_W:0];
      if (ws_ext >= d_wide) rsum = ws_ext - d_wide;
      else rsum = ws_ext + (PTR_W+1)'(DELAY_DEPTH) - d_wide;
      raddr = rsum[PTR_W-1:0];
      // entries not yet written since reset read as zero
      rd_hit = wrapped_ff || (raddr < ws_ff);
   end

   always_comb begin
      ws_in = ws_ff;
      wrapped_in = wrapped_ff;
      if (ctrl.mem_wr) begin
         if (ws_ff == PTR_W'(DELAY_DEPTH - 1)) begin
            ws_in = '0;
            wrapped_in = 1'b1;
         end else begin
            ws_in = ws_ff + 1'b1;
         end
      end
      dl = rvalid_ff ? rdata_ff[2*SB-1:SB] : '0;
      dr = rvalid_ff ? rdata_ff[SB-1:0] : '0;
      diffl_in = EW'(dl) - EW'(sl_ff);
      diffr_in = EW'(dr) - EW'(sr_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.mem_wr) delay_mem_ff[ws_ff] <= {l_ff, r_ff};
   end

   always_ff @(posedge clock) begin
      if (ctrl.mem_rd) begin
         rdata_ff <= delay_mem_ff[raddr];
         rvalid_ff <= rd_hit;
      end
   end

   always_ff @(posedge clock) begin
      xl_ff <= xl_in;
      xr_ff <= xr_in;
      g1_ff <= g1_in;
      gain_ff <= gain_in;
      l_ff <= l_in;
      r_ff <= r_in;
      nl_ff <= nl_in;
      nr_ff <= nr_in;
      diffl_ff <= diffl_in;
      diffr_ff <= diffr_in;
      prodl_ff <= prodl_in;
      prodr_ff <= prodr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= '0;
         wrapped_ff <= 1'b0;
         sl_ff <= '0;
         sr_ff <= '0;
      end else begin
         ws_ff <= ws_in;
         wrapped_ff <= wrapped_in;
         sl_ff <= sl_in;
         sr_ff <= sr_in;
      end
   end

   assign left_out = l_ff;
   assign right_out = r_ff;

endmodule

// ===== hdl/stereo_gain_crossfeed.sv =====
// stereo_gain_crossfeed: top level, gain staging and headphone crossfeed per stereo frame
//
//   channel    dir   handshake         payload
//   req_chan   in    valid / ready     left_in, right_in, frame_present
//   rsp_chan   out   valid / ready     left_out, right_out, frames_played
//   csr_*      in    csr_wr_en         csr_index, csr_wdata
//
// one frame at a time, one microcode step per cycle with both multiplier lanes shared;
// crossfeed off skips the crossfeed steps, and a muted block jumps straight to its last step.
// the next frame is taken while the previous result still sits in the output register.
// a result that is not taken holds the sequencer on its last step.
// synchronous reset loads the default config and clears lowpass state, delay fill state and the frame count.
`include "assert_macros.svh"

module stereo_gain_crossfeed import sgc_pkg::*; #(
   parameter int DELAY_DEPTH = 128,
   parameter int SAMPLE_BITS = 24
) (
   input logic                   clock,
   input logic                   reset,
   sgc_req_if.sink               req_chan,
   sgc_rsp_if.source             rsp_chan,
   input logic                   csr_wr_en,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type                       cfg_ff, cfg_in;
   logic                          present_ff, present_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic [COUNT_W-1:0]            count_ff, count_in;

   ucode_type                     seq_ctrl;
   seq_status_type                seq_status;
   logic                          req_fire;
   logic                          out_free;
   logic signed [SAMPLE_BITS-1:0] load_left, load_right;
   logic signed [SAMPLE_BITS-1:0] dp_left, dp_right;
   logic                          counted;

   assign req_chan.ready = !seq_status.busy && !reset;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // underrun frames enter as silence
   assign load_left = req_chan.frame_present ? req_chan.left_in : '0;
   assign load_right = req_chan.frame_present ? req_chan.right_in : '0;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_PLAYING:     cfg_in.playing = csr_wdata[0];
            REG_BIT_PERFECT: cfg_in.bit_perfect = csr_wdata[0];
            REG_OUTPUT_GAIN: cfg_in.output_gain = csr_wdata;
            REG_SW_VOLUME:   cfg_in.software_volume = csr_wdata;
            REG_REPLAY_GAIN: cfg_in.replay_gain = csr_wdata;
            REG_XFEED_EN:    cfg_in.crossfeed_enable = csr_wdata[0];
            REG_DELAY:       cfg_in.delay_frames = csr_wdata[DELAY_W-1:0];
            REG_ALPHA:       cfg_in.lowpass_alpha = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   sgc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .out_free (out_free),
      .cfg      (cfg_ff),
      .ctrl     (seq_ctrl),
      .status   (seq_status)
   );

   sgc_dp #(
      .DELAY_DEPTH (DELAY_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (seq_ctrl),
      .cfg       (cfg_ff),
      .load      (req_fire),
      .left_in   (load_left),
      .right_in  (load_right),
      .left_out  (dp_left),
      .right_out (dp_right)
   );

   always_comb begin
      present_in = req_fire ? req_chan.frame_present : present_ff;
      counted = present_ff && (seq_ctrl.fin == FIN_SAMPLE);
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      if (seq_status.finish) begin
         count_in = count_ff + COUNT_W'(counted);
         rsp_valid_in = 1'b1;
         rsp_left_in = (seq_ctrl.fin == FIN_SAMPLE) ? dp_left : '0;
         rsp_right_in = (seq_ctrl.fin == FIN_SAMPLE) ? dp_right : '0;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      present_ff <= present_in;
      rsp_left_ff <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.left_out = rsp_left_ff;
   assign rsp_chan.right_out = rsp_right_ff;
   assign rsp_chan.frames_played = count_ff;

   `ASSERT_IMPL(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(seq_status.finish))
   `ASSERT_IMPL(a_count_step, clock, reset, !$past(reset), count_ff - $past(count_ff) <= 48'd1)
   `ASSERT_IMPL(a_dline_wr_xfeed, clock, reset, seq_ctrl.mem_wr, cfg_ff.crossfeed_enable && cfg_ff.playing)
   `ASSERT_IMPL(a_mute_finish, clock, reset, seq_status.finish && !cfg_ff.playing, seq_ctrl.fin == FIN_MUTE)

endmodule

// ===== verif/tb.sv =====
// testbench for stereo_gain_crossfeed: predicts every frame and checks each result in order
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sgc_pkg::*;

   localparam int          SAMPLE_BITS = 24;
   localparam int          DEPTH       = 128;
   localparam longint      SAMPLE_MAX  = 64'sd8388607;
   localparam longint      SAMPLE_MIN  = -64'sd8388608;
   localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = 24'sh800000;
   localparam logic [15:0] GAIN_MAX    = 16'hFFFF;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          LONG_HOLD   = 300;
   localparam int          RANDOM_FRAMES = 500;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic                          present;
   } stereo_frame_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic [COUNT_W-1:0]            count;
   } stereo_result_type;

   class crossfeed_scoreboard;
      cfg_type            cfg;
      longint             line_l [DEPTH];
      longint             line_r [DEPTH];
      int unsigned        slot;
      longint             smooth_l;
      longint             smooth_r;
      logic [COUNT_W-1:0] delivered;
      stereo_result_type  pending [$];
      int                 mismatches;

      function new();
         cfg = CFG_RESET;
         foreach (line_l[i]) begin
            line_l[i] = 0;
            line_r[i] = 0;
         end
         slot = 0;
         smooth_l = 0;
         smooth_r = 0;
         delivered = '0;
         mismatches = 0;
      endfunction

      // round half up, then drop sh fraction bits
      function longint round_shift(longint v, int sh);
         return (v + (longint'(1) << (sh - 1))) >>> sh;
      endfunction

      function longint clamp(longint v);
         if (v > SAMPLE_MAX) return SAMPLE_MAX;
         if (v < SAMPLE_MIN) return SAMPLE_MIN;
         return v;
      endfunction

      function void note_frame(stereo_frame_type f);
         longint            l, r, g, vol, dl, dr, a, nl, nr;
         int unsigned       d, rd;
         stereo_result_type res;
         if (!cfg.playing) begin
            // muted: silence and frozen state
            res.left = '0;
            res.right = '0;
            res.count = delivered;
            pending.push_back(res);
            return;
         end
         if (f.present) begin
            l = longint'(f.left);
            r = longint'(f.right);
         end else begin
            l = 0;
            r = 0;
         end
         vol = cfg.bit_perfect ? longint'(UNITY_Q14) : longint'(cfg.software_volume);
         g = round_shift(longint'(cfg.output_gain) * vol * longint'(cfg.replay_gain),
                         GAIN_SHIFT);
         l = clamp(round_shift(l * g, SAMPLE_SHIFT));
         r = clamp(round_shift(r * g, SAMPLE_SHIFT));
         if (cfg.crossfeed_enable) begin
            // a zero delay acts as one; the field cannot exceed the last slot
            d = (cfg.delay_frames == 0) ? 1 : cfg.delay_frames;
            rd = (slot + DEPTH - d) % DEPTH;
            dl = line_l[rd];
            dr = line_r[rd];
            line_l[slot] = l;
            line_r[slot] = r;
            slot = (slot + 1) % DEPTH;
            a = longint'(cfg.lowpass_alpha);
            smooth_l += round_shift(a * (dl - smooth_l), Q16_SHIFT);
            smooth_r += round_shift(a * (dr - smooth_r), Q16_SHIFT);
            nl = l + round_shift(smooth_r * longint'(BLEED_Q16), Q16_SHIFT);
            nr = r + round_shift(smooth_l * longint'(BLEED_Q16), Q16_SHIFT);
            l = clamp(round_shift(nl * longint'(ATTEN_Q16), Q16_SHIFT));
            r = clamp(round_shift(nr * longint'(ATTEN_Q16), Q16_SHIFT));
         end
         delivered += f.present;
         res.left = l[SAMPLE_BITS-1:0];
         res.right = r[SAMPLE_BITS-1:0];
         res.count = delivered;
         pending.push_back(res);
      endfunction

      function void check_output(stereo_result_type got);
         stereo_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: L=%0d R=%0d N=%0d",
                        got.left, got.right, got.count);
            return;
         end
         want = pending.pop_front();
         if (got.left !== want.left || got.right !== want.right ||
             got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected L=%0d R=%0d N=%0d, got L=%0d R=%0d N=%0d",
                        want.left, want.right, want.count,
                        got.left, got.right, got.count);
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sgc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   sgc_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();

   stereo_gain_crossfeed dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   crossfeed_scoreboard sb;
   bit                  sender_steady;
   bit                  receiver_steady;
   bit                  hold_request;
   int                  cycle_count;
   int                  frames_sent;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type s);
      write_reg(REG_PLAYING, 16'(s.playing));
      write_reg(REG_BIT_PERFECT, 16'(s.bit_perfect));
      write_reg(REG_OUTPUT_GAIN, s.output_gain);
      write_reg(REG_SW_VOLUME, s.software_volume);
      write_reg(REG_REPLAY_GAIN, s.replay_gain);
      write_reg(REG_XFEED_EN, 16'(s.crossfeed_enable));
      write_reg(REG_DELAY, 16'(s.delay_frames));
      write_reg(REG_ALPHA, s.lowpass_alpha);
      csr_wr_en <= 1'b0;
      sb.cfg = s;
   endtask

   // valid stays high on return so back-to-back frames need no extra toggle
   task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l,
                             input logic signed [SAMPLE_BITS-1:0] r,
                             input logic present);
      int               gap;
      stereo_frame_type f;
      gap = sender_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.left_in <= l;
      req_bus.right_in <= r;
      req_bus.frame_present <= present;
      do @(posedge clock); while (!req_bus.ready);
      f.left = l;
      f.right = r;
      f.present = present;
      sb.note_frame(f);
      frames_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic collect_results();
      int                hold;
      stereo_result_type got;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold = LONG_HOLD;
         end else begin
            hold = receiver_steady ? 0 : $urandom_range(0, 15);
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.left = rsp_bus.left_out;
         got.right = rsp_bus.right_out;
         got.count = rsp_bus.frames_played;
         sb.check_output(got);
      end
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return FULL_POS;
         1: return FULL_NEG;
         2: return $urandom_range(0, 1) ? 24'sd1 : -24'sd1;
         3, 4: return 24'(int'($urandom_range(0, 131071)) - 65536);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_gain();
      case ($urandom_range(0, 5))
         0: return UNITY_Q14;
         1: return 16'd0;
         2: return GAIN_MAX;
         3: return 16'($urandom_range(8192, 24576));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type s;
      s.playing = ($urandom_range(0, 7) != 0);
      s.bit_perfect = 1'($urandom_range(0, 1));
      s.output_gain = random_gain();
      s.software_volume = random_gain();
      s.replay_gain = random_gain();
      s.crossfeed_enable = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 7))
         0: s.delay_frames = '0;
         1: s.delay_frames = '1;
         2: s.delay_frames = DELAY_W'($urandom);
         default: s.delay_frames = DELAY_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 3))
         0: s.lowpass_alpha = 16'd0;
         1: s.lowpass_alpha = GAIN_MAX;
         default: s.lowpass_alpha = 16'($urandom);
      endcase
      return s;
   endfunction

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      cfg_type s;
      int      phase;
      int      n;
      sb = new();
      sender_steady = 1'b0;
      receiver_steady = 1'b0;
      hold_request = 1'b0;
      frames_sent = 0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.left_in <= '0;
      req_bus.right_in <= '0;
      req_bus.frame_present <= 1'b0;
      rsp_bus.ready <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      fork
         collect_results();
      join_none

      // out of reset the block is muted
      send_frame(FULL_POS, FULL_NEG, 1'b1);
      send_frame(24'sh123456, -24'sd77, 1'b0);
      drain();

      // unity gain, dry path, underrun
      s = CFG_RESET;
      s.playing = 1'b1;
      apply_settings(s);
      send_frame(FULL_POS, FULL_NEG, 1'b1);
      send_frame(FULL_NEG, FULL_POS, 1'b1);
      send_frame(24'sd0, -24'sd1, 1'b1);
      send_frame(24'sd1, -24'sd1, 1'b1);
      send_frame(FULL_POS, FULL_POS, 1'b0);
      send_frame(-24'sd1, 24'sd5, 1'b1);
      drain();

      // gain overflow saturates
      s.output_gain = GAIN_MAX;
      s.software_volume = GAIN_MAX;
      s.replay_gain = GAIN_MAX;
      apply_settings(s);
      send_frame(FULL_POS, FULL_NEG, 1'b1);
      send_frame(24'sd1000, -24'sd1000, 1'b1);
      send_frame(-24'sd1, 24'sd1, 1'b1);
      drain();

      // bit-perfect ignores a zero volume
      s.bit_perfect = 1'b1;
      s.software_volume = 16'd0;
      apply_settings(s);
      send_frame(FULL_POS, FULL_NEG, 1'b1);
      send_frame(24'sd12345, -24'sd12345, 1'b1);
      drain();

      // crossfeed with a zero delay and the fastest lowpass
      s = CFG_RESET;
      s.playing = 1'b1;
      s.crossfeed_enable = 1'b1;
      s.delay_frames = '0;
      s.lowpass_alpha = GAIN_MAX;
      apply_settings(s);
      send_frame(FULL_POS, FULL_NEG, 1'b1);
      send_frame(FULL_NEG, FULL_POS, 1'b1);
      send_frame(FULL_POS, FULL_POS, 1'b1);
      send_frame(24'sd0, 24'sd0, 1'b0);
      send_frame(FULL_NEG, FULL_NEG, 1'b1);
      send_frame(24'sd100, -24'sd100, 1'b1);
      drain();

      // longest delay, lowpass frozen
      s.delay_frames = '1;
      s.lowpass_alpha = 16'd0;
      apply_settings(s);
      send_frame(FULL_POS, FULL_NEG, 1'b1);
      send_frame(FULL_NEG, FULL_POS, 1'b1);
      send_frame(24'sd4096, -24'sd4096, 1'b1);
      drain();

      frames_sent = 0;
      phase = 0;
      while (frames_sent < RANDOM_FRAMES) begin
         s = random_settings();
         if (phase == 2) begin
            // stall the result side long enough for the input to back up
            s.playing = 1'b1;
            s.crossfeed_enable = 1'b1;
            sender_steady = 1'b1;
            receiver_steady = 1'b0;
            hold_request = 1'b1;
         end else begin
            sender_steady = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
         end
         apply_settings(s);
         n = $urandom_range(20, 60);
         repeat (n) begin
            send_frame(random_sample(), random_sample(), $urandom_range(0, 7) != 0);
         end
         drain();
         phase++;
      end

      repeat (30) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
